[rtl/archive_byte_stream_decipher_core_macros.svh]
// Assertion macros used by the decipher core controller.
// Depends on nothing; assertion bodies vanish when SYNTHESIS is defined.
`ifndef ARCHIVE_BYTE_STREAM_DECIPHER_CORE_MACROS_SVH
`define ARCHIVE_BYTE_STREAM_DECIPHER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define ABSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ABSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ABSD_ASSERT_NOW(lbl, ante, cons, msg)
`define ABSD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/absd_pkg.sv]
// Package for the archive byte-stream decipher: command struct, register
// indexes, key string tables and small constant-modulus helpers. No dependencies.
package absd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FILE_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_EN = 2'd1;

    // step index of the bit-serial remainder used on reseed (6 down to 0)
    localparam logic [2:0] SEED_FIRST_SHIFT = 3'd6;

    // controller -> datapath commands
    typedef struct packed {
        logic       process_in;    // transfer without restart: decipher the port byte
        logic       capture;       // transfer with restart: hold byte, load seed
        logic       seed_step;     // one remainder step of the reseed
        logic [2:0] seed_shift;    // divisor shift for this step
        logic       process_held;  // decipher the held byte after reseed
    } cmd_t;

    // key string A, 20 characters, zero beyond
    function automatic logic [7:0] key_a_byte(input logic [4:0] idx);
        logic [7:0] k;
        case (idx)
            5'd0:    k = 8'h34;
            5'd1:    k = 8'h52;
            5'd2:    k = 8'h61;
            5'd3:    k = 8'h53;
            5'd4:    k = 8'h39;
            5'd5:    k = 8'h44;
            5'd6:    k = 8'h37;
            5'd7:    k = 8'h4B;
            5'd8:    k = 8'h61;
            5'd9:    k = 8'h45;
            5'd10:   k = 8'h62;
            5'd11:   k = 8'h78;
            5'd12:   k = 8'h63;
            5'd13:   k = 8'h70;
            5'd14:   k = 8'h32;
            5'd15:   k = 8'h6F;
            5'd16:   k = 8'h35;
            5'd17:   k = 8'h72;
            5'd18:   k = 8'h36;
            5'd19:   k = 8'h74;
            default: k = 8'h00;
        endcase
        return k;
    endfunction

    // key string B, 12 characters, zero beyond
    function automatic logic [7:0] key_b_byte(input logic [3:0] idx);
        logic [7:0] k;
        case (idx)
            4'd0:    k = 8'h33;
            4'd1:    k = 8'h74;
            4'd2:    k = 8'h52;
            4'd3:    k = 8'h61;
            4'd4:    k = 8'h55;
            4'd5:    k = 8'h78;
            4'd6:    k = 8'h4C;
            4'd7:    k = 8'h6D;
            4'd8:    k = 8'h45;
            4'd9:    k = 8'h61;
            4'd10:   k = 8'h53;
            4'd11:   k = 8'h6E;
            default: k = 8'h00;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] sub_if_ge(input logic [7:0] r, input logic [7:0] d);
        return (r >= d) ? (r - d) : r;
    endfunction

    // 7-bit value modulo fixed constants: restoring subtract of scaled divisor
    function automatic logic [3:0] mod9(input logic [6:0] k);
        logic [7:0] r;
        r = sub_if_ge({1'b0, k}, 8'd72);
        r = sub_if_ge(r, 8'd36);
        r = sub_if_ge(r, 8'd18);
        r = sub_if_ge(r, 8'd9);
        return r[3:0];
    endfunction

    function automatic logic [3:0] mod15(input logic [6:0] k);
        logic [7:0] r;
        r = sub_if_ge({1'b0, k}, 8'd120);
        r = sub_if_ge(r, 8'd60);
        r = sub_if_ge(r, 8'd30);
        r = sub_if_ge(r, 8'd15);
        return r[3:0];
    endfunction

    function automatic logic [3:0] mod12(input logic [6:0] k);
        logic [7:0] r;
        r = sub_if_ge({1'b0, k}, 8'd96);
        r = sub_if_ge(r, 8'd48);
        r = sub_if_ge(r, 8'd24);
        r = sub_if_ge(r, 8'd12);
        return r[3:0];
    endfunction

    function automatic logic [2:0] mod7(input logic [6:0] k);
        logic [7:0] r;
        r = sub_if_ge({1'b0, k}, 8'd112);
        r = sub_if_ge(r, 8'd56);
        r = sub_if_ge(r, 8'd28);
        r = sub_if_ge(r, 8'd14);
        r = sub_if_ge(r, 8'd7);
        return r[2:0];
    endfunction

    function automatic logic [2:0] mod5(input logic [6:0] k);
        logic [7:0] r;
        r = sub_if_ge({1'b0, k}, 8'd80);
        r = sub_if_ge(r, 8'd40);
        r = sub_if_ge(r, 8'd20);
        r = sub_if_ge(r, 8'd10);
        r = sub_if_ge(r, 8'd5);
        return r[2:0];
    endfunction

endpackage

[rtl/absd_ctrl.sv]
// Controller for the decipher core: transfer handshakes, output register
// occupancy and the reseed sequence. Uses absd_pkg and the assertion macros.
`include "archive_byte_stream_decipher_core_macros.svh"

module absd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              restart,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output absd_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_READY = 2'd0;
    localparam logic [1:0] ST_SEED  = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [2:0] step_reg;
    logic [2:0] step_next;
    logic       out_full_reg;
    logic       out_full_next;
    logic       out_free;
    logic       in_xfer;
    logic       load_out;

    // output slot can take a result this cycle
    assign out_free = !out_full_reg || !out_stall;
    assign in_stall = (state_reg != ST_READY) || !out_free;
    assign in_xfer  = in_valid && !in_stall;
    assign out_valid = out_full_reg;

    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        cmd.process_in    = 1'b0;
        cmd.capture       = 1'b0;
        cmd.seed_step     = 1'b0;
        cmd.seed_shift    = step_reg;
        cmd.process_held  = 1'b0;
        unique case (state_reg)
            ST_READY:
            begin
                if (in_xfer)
                begin
                    if (restart)
                    begin
                        cmd.capture = 1'b1;
                        step_next   = absd_pkg::SEED_FIRST_SHIFT;
                        state_next  = ST_SEED;
                    end
                    else
                    begin
                        cmd.process_in = 1'b1;
                    end
                end
            end
            ST_SEED:
            begin
                cmd.seed_step = 1'b1;
                step_next     = step_reg - 3'd1;
                if (step_reg == 3'd0)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.process_held = 1'b1;
                    state_next       = ST_READY;
                end
            end
            default:
            begin
                state_next = ST_READY;
            end
        endcase
    end

    assign load_out = cmd.process_in || cmd.process_held;

    always_comb
    begin
        out_full_next = out_full_reg;
        if (load_out)
        begin
            out_full_next = 1'b1;
        end
        else if (out_full_reg && !out_stall)
        begin
            out_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_READY;
            step_reg     <= 3'd0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            out_full_reg <= out_full_next;
        end
    end

    `ABSD_ASSERT_NOW(a_no_overwrite, load_out, out_free, "result register overwritten while stalled")
    `ABSD_ASSERT_NEXT(a_restart_seeds, in_xfer && restart, state_reg == ST_SEED, "restart did not start reseed")
    `ABSD_ASSERT_NEXT(a_seed_done, (state_reg == ST_SEED) && (step_reg == 3'd0), state_reg == ST_EMIT, "reseed did not finish after last step")
    `ABSD_ASSERT_NOW(a_busy_stalls, state_reg != ST_READY, in_stall, "input taken during reseed")
    `ABSD_ASSERT_NEXT(a_load_shows, load_out, out_valid, "loaded result not presented")

endmodule

[rtl/absd_dp.sv]
// Datapath for the decipher core: configuration registers, keystream state,
// byte mixing, position advance and bit-serial reseed remainder. Uses absd_pkg.
module absd_dp
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [absd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [absd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [7:0]                         cipher_byte,
    input  absd_pkg::cmd_t                     cmd,
    output logic [7:0]                         plain_byte
);

    logic [31:0] file_size_reg;
    logic        decrypt_en_reg;
    logic [6:0]  kc_reg;
    logic [6:0]  kc_next;
    logic [4:0]  pos_a_reg;
    logic [4:0]  pos_a_next;
    logic [3:0]  pos_b_reg;
    logic [3:0]  pos_b_next;
    logic        swap_reg;
    logic        swap_next;
    logic [7:0]  held_byte_reg;
    logic [6:0]  rem_reg;
    logic [6:0]  rem_next;
    logic [7:0]  out_byte_reg;

    logic [7:0]  byte_sel;
    logic [7:0]  mix_b;
    logic [7:0]  mix_s;
    logic [7:0]  result;
    logic        do_out;
    logic [4:0]  inc_a;
    logic [3:0]  inc_b;
    logic        wrap_a;
    logic        wrap_b;
    logic [6:0]  kc_inc;
    logic [6:0]  seed_kc;
    logic [10:0] div_sh;
    logic [10:0] rem_ext;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_size_reg  <= 32'd0;
            decrypt_en_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                absd_pkg::CFG_FILE_SIZE:  file_size_reg  <= cfg_data;
                absd_pkg::CFG_DECRYPT_EN: decrypt_en_reg <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    assign do_out = cmd.process_in || cmd.process_held;

    // byte mixing
    always_comb
    begin
        byte_sel = cmd.process_held ? held_byte_reg : cipher_byte;
        mix_b    = byte_sel ^ {1'b0, kc_reg} ^ absd_pkg::key_b_byte(pos_b_reg);
        mix_s    = swap_reg ? {mix_b[3:0], mix_b[7:4]} : mix_b;
        result   = decrypt_en_reg ? (mix_s ^ absd_pkg::key_a_byte(pos_a_reg)) : byte_sel;
    end

    // reseed: counter from size bits 8..2, pos_a from a serial remainder by pos_b
    assign seed_kc = file_size_reg[8:2];
    assign div_sh  = {7'd0, pos_b_reg} << cmd.seed_shift;
    assign rem_ext = {4'd0, rem_reg};

    always_comb
    begin
        rem_next = rem_reg;
        if (cmd.capture)
        begin
            rem_next = seed_kc;
        end
        else if (cmd.seed_step && (rem_ext >= div_sh))
        begin
            rem_next = rem_reg - div_sh[6:0];
        end
    end

    // position advance and state update
    always_comb
    begin
        inc_a  = pos_a_reg + 5'd1;
        inc_b  = pos_b_reg + 4'd1;
        wrap_a = inc_a > 5'd19;
        wrap_b = inc_b > 4'd11;
        kc_inc = kc_reg + 7'd1;

        kc_next    = kc_reg;
        pos_a_next = pos_a_reg;
        pos_b_next = pos_b_reg;
        swap_next  = swap_reg;

        if (cmd.capture)
        begin
            kc_next    = seed_kc;
            pos_b_next = 4'd1 + absd_pkg::mod9(seed_kc);
            swap_next  = 1'b0;
        end
        else if (cmd.seed_step)
        begin
            // final step leaves remainder < pos_b
            pos_a_next = 5'(rem_next) + 5'd1;
        end
        else if (do_out && decrypt_en_reg)
        begin
            if (wrap_a && wrap_b)
            begin
                kc_next = kc_inc;
                if (!swap_reg)
                begin
                    swap_next  = 1'b1;
                    pos_a_next = 5'd3 + {1'b0, absd_pkg::mod15(kc_inc)};
                    pos_b_next = 4'd1 + {1'b0, absd_pkg::mod7(kc_inc)};
                end
                else
                begin
                    swap_next  = 1'b0;
                    pos_a_next = 5'd6 + {1'b0, absd_pkg::mod12(kc_inc)};
                    pos_b_next = 4'd4 + {1'b0, absd_pkg::mod5(kc_inc)};
                end
            end
            else
            begin
                pos_a_next = wrap_a ? 5'd1 : inc_a;
                pos_b_next = wrap_b ? 4'd1 : inc_b;
                swap_next  = swap_reg ^ wrap_a ^ wrap_b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kc_reg    <= 7'd0;
            pos_a_reg <= 5'd1;
            pos_b_reg <= 4'd1;
            swap_reg  <= 1'b0;
        end
        else
        begin
            kc_reg    <= kc_next;
            pos_a_reg <= pos_a_next;
            pos_b_reg <= pos_b_next;
            swap_reg  <= swap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        if (cmd.capture)
        begin
            held_byte_reg <= cipher_byte;
        end
        if (do_out)
        begin
            out_byte_reg <= result;
        end
    end

    assign plain_byte = out_byte_reg;

endmodule

[rtl/archive_byte_stream_decipher_core.sv]
// Top level of the archive byte-stream decipher core.
// Instantiates absd_ctrl and absd_dp; uses absd_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall, cipher_byte, restart) takes one raw
//   archive byte per transfer; output channel (out_valid / out_stall,
//   plain_byte) returns exactly one deciphered byte per input transfer, in order.
//   Config port (cfg_we, cfg_index, cfg_data): index 0 = file size, index 1 =
//   decrypt enable (bit 0); other indexes ignored. Write only while idle.
// Throughput and reseed:
//   A byte without restart is mixed in the cycle it is taken and shows on the
//   output in the next cycle; one byte per cycle is sustained while out_stall
//   is low, as the output register is refilled in the same cycle its contents
//   are taken. With restart, the byte is held while the new pos_a (one plus
//   a remainder by pos_b) is computed by a single subtract unit, one quotient
//   bit per cycle, and is then mixed; in_stall stays high meanwhile.
// Reset: keystream counter 0, positions 1/1, no nibble swap, file size 0,
//   decrypt enabled; output empty.
// Stall: while out_stall holds a full output register, in_stall is raised and
//   plain_byte holds its value.
module archive_byte_stream_decipher_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [absd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [absd_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        cipher_byte,
    input  logic                              restart,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        plain_byte
);

    absd_pkg::cmd_t cmd;

    // handshakes, output occupancy, reseed sequencing
    absd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .restart   (restart),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // registers, keystream state and byte mixing
    absd_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cipher_byte (cipher_byte),
        .cmd         (cmd),
        .plain_byte  (plain_byte)
    );

endmodule

[tb/sv/tb_archive_byte_stream_decipher_core.sv]
// Self-checking testbench for archive_byte_stream_decipher_core: a scoreboard class
// predicts each plain byte, and tasks drive the config port and both handshake channels.
// Depends on absd_pkg and the decipher core RTL.
`timescale 1ns / 100ps

class decipher_scoreboard;
    // key strings, first character in the top byte
    localparam logic [159:0] KEY_A = "4RaS9D7KaEbxcp2o5r6t";
    localparam logic [95:0]  KEY_B = "3tRaUxLmEaSn";

    logic [31:0] file_size;
    bit          decrypt_on;
    logic [6:0]  key_ctr;
    logic [4:0]  pos_a;
    logic [3:0]  pos_b;
    bit          swap_nib;
    logic [7:0]  plain_due[$];
    int          mismatches;

    function new();
        file_size  = '0;
        decrypt_on = 1'b1;
        key_ctr    = '0;
        pos_a      = 5'd1;
        pos_b      = 4'd1;
        swap_nib   = 1'b0;
        mismatches = 0;
    endfunction

    function int outstanding();
        return plain_due.size();
    endfunction

    function void set_register(logic [absd_pkg::CFG_IDX_W-1:0] idx,
                               logic [absd_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            absd_pkg::CFG_FILE_SIZE:  file_size = data;
            absd_pkg::CFG_DECRYPT_EN: decrypt_on = data[0];
            default: ;
        endcase
    endfunction

    function logic [7:0] key_a_at(logic [4:0] p);
        return (p < 20) ? 8'(KEY_A >> (8 * (19 - p))) : 8'h00;
    endfunction

    function logic [7:0] key_b_at(logic [3:0] p);
        return (p < 12) ? 8'(KEY_B >> (8 * (11 - p))) : 8'h00;
    endfunction

    function void reseed();
        key_ctr  = file_size[8:2];
        pos_b    = 4'(1 + key_ctr % 9);
        pos_a    = 5'(1 + key_ctr % pos_b);
        swap_nib = 1'b0;
    endfunction

    function void step_positions();
        int a;
        int b;
        a = (pos_a + 1) & 31;
        b = (pos_b + 1) & 15;
        if (a > 19 && b > 11)
        begin
            key_ctr = key_ctr + 7'd1;
            if (!swap_nib)
            begin
                swap_nib = 1'b1;
                a = 3 + key_ctr % 15;
                b = 1 + key_ctr % 7;
            end
            else
            begin
                swap_nib = 1'b0;
                a = 6 + key_ctr % 12;
                b = 4 + key_ctr % 5;
            end
        end
        else
        begin
            if (a > 19)
            begin
                a = 1;
                swap_nib = ~swap_nib;
            end
            if (b > 11)
            begin
                b = 1;
                swap_nib = ~swap_nib;
            end
        end
        pos_a = 5'(a);
        pos_b = 4'(b);
    endfunction

    // accepted input transfer: work out the plain byte it must produce
    function void take_cipher_byte(logic [7:0] c, logic rs);
        logic [7:0] p;
        if (rs)
            reseed();
        p = c;
        if (decrypt_on)
        begin
            p = c ^ {1'b0, key_ctr} ^ key_b_at(pos_b);
            if (swap_nib)
                p = {p[3:0], p[7:4]};
            p = p ^ key_a_at(pos_a);
            step_positions();
        end
        plain_due.push_back(p);
    endfunction

    function void check_plain_byte(logic [7:0] actual);
        logic [7:0] want;
        if (plain_due.size() == 0)
        begin
            $error("plain_byte: transfer with nothing pending, actual %02h", actual);
            mismatches++;
            return;
        end
        want = plain_due.pop_front();
        if (actual !== want)
        begin
            $error("plain_byte: expected %02h, actual %02h", want, actual);
            mismatches++;
        end
    endfunction

    function void flush_leftovers();
        if (plain_due.size() != 0)
        begin
            $error("plain_byte: %0d expected transfers never came, first expected %02h",
                   plain_due.size(), plain_due[0]);
            mismatches++;
        end
    endfunction
endclass

module tb_archive_byte_stream_decipher_core;

    localparam int N_ITEMS       = 1850;
    localparam int LONG_HOLD     = 300;   // receiver hold-off, long enough to back up the input
    localparam int QUIET_LIMIT   = 2000;  // cycles with no transfer before giving up
    localparam int SETTLE_CYCLES = 12;    // covers the restart sequence, with margin

    // indexes past the last register; writes there must be ignored
    localparam logic [absd_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [absd_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [absd_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [absd_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    logic [7:0]                      cipher_byte;
    logic                            restart;
    logic                            out_valid;
    logic                            out_stall;
    logic [7:0]                      plain_byte;

    // pacing knobs shared between the stimulus and the receiver
    bit tx_steady;
    bit rx_steady;
    bit hold_off_req;
    int sent;

    decipher_scoreboard sb = new();

    archive_byte_stream_decipher_core uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cipher_byte (cipher_byte),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .plain_byte  (plain_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Monitor: everything is sampled at the rising edge, where the inputs
    // (driven on the falling edge) are stable. Register writes go into the
    // predictor first, then the input transfer, then the output transfer;
    // an output never belongs to an input taken on the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.set_register(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                sb.take_cipher_byte(cipher_byte, restart);
            if (out_valid && !out_stall)
                sb.check_plain_byte(plain_byte);
        end
    end

    // Watchdog: a run that moves no transfer for too long is a hang.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: before each result it stalls for a hold drawn at random (none when
    // steady), or one long stretch when the stimulus asks for it. One stall update
    // per falling edge at most.
    initial
    begin : receiver
        int hold;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold = LONG_HOLD;
                hold_off_req = 1'b0;
            end
            else if (rx_steady)
                hold = 0;
            else
                hold = $urandom_range(0, 9);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    task automatic write_reg(input logic [absd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [absd_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One input transfer. valid stays high across back-to-back items; it is
    // only dropped when a gap is drawn.
    task automatic send_byte(input logic [7:0] c, input logic rs);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        cipher_byte <= c;
        restart     <= rs;
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    // Stop offering, wait for every pending plain byte, then let the core settle.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int                              phase;
        int                              len;
        int                              restart_odds;
        logic                            rs;
        logic [absd_pkg::CFG_DATA_W-1:0] val;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        cipher_byte = '0;
        restart     = 1'b0;
        tx_steady   = 1'b0;
        rx_steady   = 1'b0;
        hold_off_req = 1'b0;
        sent        = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // --- directed ---
        // key state straight out of reset, byte extremes
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        // restart with a zero file size
        send_byte(8'h5A, 1'b1);
        send_byte(8'h3C, 1'b0);
        drain();

        // largest file size: seed bits all ones
        write_reg(absd_pkg::CFG_FILE_SIZE, 32'hFFFF_FFFF);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h81, 1'b0);
        drain();

        // pass-through; upper data bits set must not matter
        write_reg(absd_pkg::CFG_DECRYPT_EN, 32'hFFFF_FFFE);
        send_byte(8'h12, 1'b0);
        send_byte(8'hFF, 1'b0);
        drain();

        // restart while disabled still reseeds; seed field alone set
        write_reg(absd_pkg::CFG_FILE_SIZE, 32'h0000_01FC);
        send_byte(8'h00, 1'b1);
        send_byte(8'h7E, 1'b0);
        drain();

        // back to deciphering, and writes to spare indexes do nothing
        write_reg(absd_pkg::CFG_DECRYPT_EN, 32'h0000_0001);
        write_reg(CFG_SPARE_A, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_B, 32'h0000_0000);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h00, 1'b0);
        drain();

        // everything but the seed field set
        write_reg(absd_pkg::CFG_FILE_SIZE, 32'hFFFF_FE03);
        send_byte(8'h99, 1'b1);
        send_byte(8'h66, 1'b0);

        // --- random phases ---
        // Each phase: new registers while idle, then a run of bytes. Half the
        // phases restart only at the top so the positions run through many
        // wraps, including the double wrap that bumps the counter.
        phase = 0;
        while (sent < N_ITEMS)
        begin
            drain();
            case ($urandom_range(0, 5))
                0:       val = '0;
                1:       val = '1;
                default: val = $urandom();
            endcase
            write_reg(absd_pkg::CFG_FILE_SIZE, val);
            val = $urandom();
            val[0] = ($urandom_range(0, 4) != 0);
            write_reg(absd_pkg::CFG_DECRYPT_EN, val);
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom());

            tx_steady    = ($urandom_range(0, 3) == 0);
            rx_steady    = ($urandom_range(0, 3) == 0);
            len          = $urandom_range(20, 300);
            restart_odds = $urandom_range(0, 1) ? 30 : 0;

            // back-pressure: receiver sits still while the sender keeps offering
            if (phase == 1)
            begin
                tx_steady    = 1'b1;
                hold_off_req = 1'b1;
            end

            for (int i = 0; i < len; i++)
            begin
                // sender pause: nothing offered until every result is back
                if (phase == 3 && i == len / 2)
                    drain();
                if (i == 0)
                    rs = $urandom_range(0, 1);
                else
                    rs = (restart_odds != 0) && ($urandom_range(1, restart_odds) == 1);
                send_byte(8'($urandom()), rs);
            end
            phase++;
        end

        drain();
        repeat (20) @(posedge clk);
        sb.flush_leftovers();
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
